@@ src/length_prefixed_crc16_deframer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed CRC-16 deframer
// Clocked concurrent assertion forms, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_CRC16_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_CRC16_DEFRAMER_ASSERT_SVH

// checked only outside reset
`define LPCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LPCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lpcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_pkg
// Types, codes and the byte-wide CRC-16 update of the deframer.
// ----------------------------------------------------------------------------
package lpcd_pkg;

  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [7:0]  MAX_LEN_RESET = 8'd253;
  localparam logic [7:0]  MIN_LEN_EXCL  = 8'd2;
  localparam logic [7:0]  CRC_BYTES     = 8'd2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_OK      = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_BAD_LEN = 2'd3
  } result_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abort_frame;
  } in_item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   payload_byte;
    logic [7:0]   payload_count;
  } result_t;

  // Reflected CRC-16 (Modbus), one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/length_prefixed_crc16_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_crc16_deframer
// Splits length-prefixed frames and checks their Modbus CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per transaction in tdata; tuser[0]
//   set drops any frame in progress and the byte is ignored.
//   The first byte of a frame is its total length L (3..max length); the
//   CRC-16 over all L bytes must end at zero. Bytes 1..L-3 come out as
//   payload results; the last byte gives an ok or crc-error verdict with
//   the payload count. A bad length byte gives a bad-length result.
//   m_axis tuser holds the result kind, tdata the payload byte and count.
//   cfg writes the maximum length; write it only while the block is idle.
// Timing:
//   One byte per cycle sustained while m_axis takes results. A result
//   passes through the input register, then the result register, before
//   it is valid on m_axis; the CRC byte update sits between the two.
//   Reset clears both registers, returns to idle and sets max length 253.
//   When m_axis stalls, the result register holds, the input register
//   keeps its byte (or takes one more if empty) and s_axis_tready stays
//   low until the waiting result is taken.
// ----------------------------------------------------------------------------
module length_prefixed_crc16_deframer
  import lpcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] abort_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_count
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // [7:0] max_frame_length
);

  logic       max_len;
  logic [7:0] max_frame_length;
  logic       item_valid;
  logic       take;
  in_item_t   item;
  result_t    result;

  assign cfg_ready = 1'b1;
  assign max_len   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_RESET;
    end else if (max_len) begin
      max_frame_length <= cfg_data;
    end
  end

  lpcd_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take          (take),
    .item_valid    (item_valid),
    .item          (item)
  );

  lpcd_frame_ctl u_frame_ctl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .max_len    (max_frame_length),
    .take       (take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .result     (result)
  );

  assign m_axis_tdata = {result.payload_count, result.payload_byte};
  assign m_axis_tuser = result.result_kind;

endmodule

@@ src/lpcd_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_in_reg
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module lpcd_in_reg
  import lpcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0] s_axis_tuser,   // [0] abort_frame
  input  logic       take,
  output logic       item_valid,
  output in_item_t   item
);

  assign s_axis_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.rx_byte     <= s_axis_tdata;
      item.abort_frame <= s_axis_tuser[0];
    end
  end

endmodule

@@ src/lpcd_frame_ctl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_frame_ctl
// Frame tracking, CRC update and the result register.
// ----------------------------------------------------------------------------
module lpcd_frame_ctl
  import lpcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  in_item_t   item,
  input  logic [7:0] max_len,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    result
);

  logic        in_frame, in_frame_next;
  logic [7:0]  frame_len, frame_len_next;
  logic [7:0]  byte_pos, byte_pos_next;
  logic [15:0] crc, crc_next;
  logic [15:0] crc_upd;
  logic        emit;
  result_t     res_next;

  assign take    = item_valid && (!out_valid || out_ready);
  // crc holds the initial value while idle, so one update serves both cases
  assign crc_upd = crc_byte(crc, item.rx_byte);

  always_comb begin
    in_frame_next  = in_frame;
    frame_len_next = frame_len;
    byte_pos_next  = byte_pos;
    crc_next       = crc;
    emit           = 1'b0;
    res_next       = '{result_kind: KIND_PAYLOAD, payload_byte: 8'h00, payload_count: 8'h00};

    if (item.abort_frame) begin
      in_frame_next  = 1'b0;
      frame_len_next = 8'h00;
      byte_pos_next  = 8'h00;
      crc_next       = CRC_INIT;
    end else if (!in_frame) begin
      if (item.rx_byte <= MIN_LEN_EXCL || item.rx_byte > max_len) begin
        emit                 = 1'b1;
        res_next.result_kind = KIND_BAD_LEN;
      end else begin
        in_frame_next  = 1'b1;
        frame_len_next = item.rx_byte;
        byte_pos_next  = 8'd1;
        crc_next       = crc_upd;
      end
    end else if ({1'b0, byte_pos} + 9'd3 <= {1'b0, frame_len}) begin
      crc_next              = crc_upd;
      byte_pos_next         = byte_pos + 8'd1;
      emit                  = 1'b1;
      res_next.payload_byte = item.rx_byte;
    end else if (byte_pos + CRC_BYTES == frame_len) begin
      // first CRC byte: folded in, nothing to report
      crc_next      = crc_upd;
      byte_pos_next = byte_pos + 8'd1;
    end else begin
      emit                   = 1'b1;
      res_next.result_kind   = (crc_upd == 16'h0000) ? KIND_OK : KIND_CRC_ERR;
      res_next.payload_count = frame_len - 8'd3;
      in_frame_next          = 1'b0;
      frame_len_next         = 8'h00;
      byte_pos_next          = 8'h00;
      crc_next               = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      frame_len <= 8'h00;
      byte_pos  <= 8'h00;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        in_frame  <= in_frame_next;
        frame_len <= frame_len_next;
        byte_pos  <= byte_pos_next;
        crc       <= crc_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result <= res_next;
    end
  end

endmodule

@@ src/lpcd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
`include "length_prefixed_crc16_deframer_assert.svh"

module lpcd_checker
  import lpcd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  `LPCD_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_axis_tvalid, "result after reset")

  `LPCD_ASSERT(a_hold_on_stall,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result changed while stalled")

  `LPCD_ASSERT(a_count_only_on_verdict,
    m_axis_tvalid && (m_axis_tuser == KIND_PAYLOAD || m_axis_tuser == KIND_BAD_LEN) |->
      m_axis_tdata[15:8] == 8'h00,
    "payload count on a non-verdict result")

  `LPCD_ASSERT(a_byte_only_on_payload,
    m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |-> m_axis_tdata[7:0] == 8'h00,
    "payload byte on a non-payload result")

endmodule

bind length_prefixed_crc16_deframer lpcd_checker u_lpcd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
